// ===== rtl/core/scs_pkg.sv =====
// scs_pkg: shared types, codes and constants of the step chaser sequencer
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package scs_pkg;

	// default table depth and command queue depth
	localparam int SCS_MAX_STEPS   = 64;
	localparam int SCS_QUEUE_DEPTH = 2;

	// configuration register reset values
	localparam logic        RST_START_DIR  = 1'b0;
	localparam logic [1:0]  RST_RUN_ORDER  = 2'd1;
	localparam logic [15:0] RST_HOLD_TICKS = 16'd50;
	localparam logic [6:0]  RST_STEP_COUNT = 7'd0;

	// configuration register indexes
	localparam logic [1:0] REG_START_DIR  = 2'd0;
	localparam logic [1:0] REG_RUN_ORDER  = 2'd1;
	localparam logic [1:0] REG_HOLD_TICKS = 2'd2;
	localparam logic [1:0] REG_STEP_COUNT = 2'd3;

	// run order codes
	localparam logic [1:0] ORD_SINGLE = 2'd0;
	localparam logic [1:0] ORD_LOOP   = 2'd1;
	localparam logic [1:0] ORD_PING   = 2'd2;

	// input action codes
	localparam logic [2:0] ACT_LOAD  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_TICK  = 3'd2;
	localparam logic [2:0] ACT_TAP   = 3'd3;
	localparam logic [2:0] ACT_STOP  = 3'd4;

	// decoded command kinds carried through the queue
	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_START = 3'd1,
		OP_TICK  = 3'd2,
		OP_TAP   = 3'd3,
		OP_STOP  = 3'd4
	} op_t;

	// result event kinds
	typedef enum logic [1:0] {
		EV_START  = 2'd0,
		EV_STOP   = 2'd1,
		EV_FINISH = 2'd2
	} ev_kind_t;

	// one queued command
	typedef struct packed {
		op_t         op;
		logic [5:0]  slot;
		logic [15:0] ident;
	} cmd_t;

	// configuration seen by the back end
	typedef struct packed {
		logic        start_direction;
		logic [1:0]  run_order;
		logic [15:0] hold_ticks;
		logic [6:0]  step_count;
	} cfg_t;

endpackage

// ===== rtl/core/scs_front.sv =====
// scs_front: accepts input transactions, decodes the action and drops
// the ones that can never have an effect; uses scs_pkg
`timescale 1ns / 1ps

module scs_front #(
	parameter int MAX_STEPS = scs_pkg::SCS_MAX_STEPS
) (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        action,
	input  logic [5:0]        step_slot,
	input  logic [15:0]       step_ident,
	input  logic              q_full,
	output logic              q_push,
	output scs_pkg::cmd_t     q_cmd
);
	import scs_pkg::*;

	logic keep;
	op_t  op;

	// hold off the producer while the queue has no room
	assign in_stall = q_full;

	// classify the action; unknown codes and loads beyond the table vanish
	always_comb begin
		keep = 1'b1;
		op   = OP_LOAD;
		unique case (action)
			ACT_LOAD: begin
				op   = OP_LOAD;
				keep = (32'(step_slot) < MAX_STEPS);
			end
			ACT_START: op = OP_START;
			ACT_TICK:  op = OP_TICK;
			ACT_TAP:   op = OP_TAP;
			ACT_STOP:  op = OP_STOP;
			default:   keep = 1'b0;
		endcase
	end

	assign q_push      = in_valid && !q_full && keep;
	assign q_cmd.op    = op;
	assign q_cmd.slot  = step_slot;
	assign q_cmd.ident = step_ident;

endmodule

// ===== rtl/core/scs_cmd_fifo.sv =====
// scs_cmd_fifo: short command queue between front and back end
// uses scs_pkg for the command type and depth
`timescale 1ns / 1ps

module scs_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  scs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output scs_pkg::cmd_t head_cmd
);
	import scs_pkg::*;

	localparam int DEPTH = SCS_QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/scs_back.sv =====
// scs_back: carries out queued commands, holds the step table and run state,
// and drives the registered result channel; uses scs_pkg
`timescale 1ns / 1ps

module scs_back #(
	parameter int MAX_STEPS = scs_pkg::SCS_MAX_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scs_pkg::cfg_t cfg,
	input  logic          q_not_empty,
	input  scs_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    event_kind,
	output logic [5:0]    member_index,
	output logic [15:0]   member_ident,
	output logic          last_of_run
);
	import scs_pkg::*;

	localparam int PW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int NW  = $clog2(MAX_STEPS + 1);
	localparam int CW  = NW + 1;
	localparam int IW  = (PW > 6) ? PW : 6;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_EV1  = 3'b010,
		BK_EV2  = 3'b100
	} bk_state_t;

	bk_state_t     state_q, state_d;

	// run state
	logic [PW-1:0] pos_q, pos_d;
	logic          back_q, back_d;
	logic          active_q, active_d;
	logic [15:0]   hold_q, hold_d;

	// pending events of the command in flight
	ev_kind_t      ev1_kind_q, ev1_kind_d;
	logic [PW-1:0] ev1_pos_q, ev1_pos_d;
	logic          ev1_last_q, ev1_last_d;
	logic          ev2_vld_q, ev2_vld_d;
	ev_kind_t      ev2_kind_q, ev2_kind_d;
	logic [PW-1:0] ev2_pos_q, ev2_pos_d;

	// step table
	logic [15:0]   table_mem [MAX_STEPS];
	logic [15:0]   rd_data_q;
	logic          mem_we;
	logic [PW-1:0] mem_wa;
	logic          mem_re;
	logic [PW-1:0] mem_ra;
	logic [IW-1:0] slot_ext;

	// output register
	logic          out_valid_q;
	ev_kind_t      out_kind_q;
	logic [5:0]    out_index_q;
	logic [15:0]   out_ident_q;
	logic          out_last_q;
	logic          out_free;
	logic          out_load;
	ev_kind_t      ld_kind;
	logic [PW-1:0] ld_pos;
	logic          ld_last;
	logic [IW-1:0] ld_pos_ext;

	// end-of-step arithmetic
	logic [NW-1:0] n_eff;
	logic [CW-1:0] n_w;
	logic [CW-1:0] p_w;
	logic [CW-1:0] end_pos_w;
	logic          end_back;
	logic          end_ok;
	logic [CW-1:0] start_pos_w;
	logic [15:0]   hold_eff;
	logic [16:0]   hold_inc;
	logic          do_end;

	// effective step count and hold time
	always_comb begin
		if (32'(cfg.step_count) < MAX_STEPS) begin
			n_eff = NW'(cfg.step_count);
		end else begin
			n_eff = NW'(MAX_STEPS);
		end
		n_w      = CW'(n_eff);
		p_w      = CW'(pos_q);
		hold_eff = (cfg.hold_ticks == 16'd0) ? 16'd1 : cfg.hold_ticks;
		hold_inc = {1'b0, hold_q} + 17'd1;
	end

	// next position when the current step ends
	always_comb begin
		end_pos_w = p_w;
		end_back  = back_q;
		end_ok    = 1'b1;
		priority if (!back_q && (p_w + 1'b1 < n_w)) begin
			end_pos_w = p_w + 1'b1;
		end else if (back_q && (p_w != '0) && (p_w - 1'b1 < n_w)) begin
			end_pos_w = p_w - 1'b1;
		end else if ((n_w == '0) ||
			((cfg.run_order != ORD_LOOP) && (cfg.run_order != ORD_PING))) begin
			end_ok = 1'b0;
		end else if (cfg.run_order == ORD_LOOP) begin
			end_pos_w = back_q ? (n_w - 1'b1) : '0;
		end else begin
			if (!back_q) begin
				end_pos_w = (n_w >= CW'(2)) ? (n_w - CW'(2)) : '0;
			end else begin
				end_pos_w = (n_w >= CW'(2)) ? CW'(1) : '0;
			end
			end_back = !back_q;
		end
	end

	// first position of a fresh run
	assign start_pos_w = (cfg.start_direction && (n_w != '0)) ? (n_w - 1'b1) : '0;

	assign out_free = !out_valid_q || !out_stall;
	assign slot_ext = IW'(q_cmd.slot);

	// command sequencer
	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		back_d     = back_q;
		active_d   = active_q;
		hold_d     = hold_q;
		ev1_kind_d = ev1_kind_q;
		ev1_pos_d  = ev1_pos_q;
		ev1_last_d = ev1_last_q;
		ev2_vld_d  = ev2_vld_q;
		ev2_kind_d = ev2_kind_q;
		ev2_pos_d  = ev2_pos_q;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		mem_wa     = slot_ext[PW-1:0];
		mem_re     = 1'b0;
		mem_ra     = pos_q;
		out_load   = 1'b0;
		ld_kind    = ev1_kind_q;
		ld_pos     = ev1_pos_q;
		ld_last    = ev1_last_q;
		do_end     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_not_empty) begin
					q_pop = 1'b1;
					unique case (q_cmd.op)
						OP_LOAD: begin
							mem_we = 1'b1;
						end
						OP_START: begin
							back_d     = cfg.start_direction;
							pos_d      = PW'(start_pos_w);
							ev1_last_d = 1'b1;
							ev2_vld_d  = 1'b0;
							state_d    = BK_EV1;
							if (n_w != '0) begin
								active_d   = 1'b1;
								hold_d     = '0;
								ev1_kind_d = EV_START;
								ev1_pos_d  = PW'(start_pos_w);
								mem_re     = 1'b1;
								mem_ra     = PW'(start_pos_w);
							end else begin
								active_d   = 1'b0;
								ev1_kind_d = EV_FINISH;
								ev1_pos_d  = '0;
							end
						end
						OP_TICK: begin
							if (active_q) begin
								hold_d = hold_inc[15:0];
								do_end = (hold_inc >= {1'b0, hold_eff});
							end
						end
						OP_TAP: begin
							do_end = active_q;
						end
						OP_STOP: begin
							if (active_q) begin
								active_d   = 1'b0;
								ev1_kind_d = EV_FINISH;
								ev1_pos_d  = '0;
								ev1_last_d = 1'b1;
								ev2_vld_d  = 1'b0;
								state_d    = BK_EV1;
							end
						end
						default: ;
					endcase
					// stop event for the current member, then the next member's start or a finish
					if (do_end) begin
						ev1_kind_d = EV_STOP;
						ev1_pos_d  = pos_q;
						ev1_last_d = 1'b0;
						mem_re     = 1'b1;
						mem_ra     = pos_q;
						ev2_vld_d  = 1'b1;
						back_d     = end_back;
						active_d   = end_ok;
						state_d    = BK_EV1;
						if (end_ok) begin
							pos_d      = PW'(end_pos_w);
							hold_d     = '0;
							ev2_kind_d = EV_START;
							ev2_pos_d  = PW'(end_pos_w);
						end else begin
							ev2_kind_d = EV_FINISH;
							ev2_pos_d  = '0;
						end
					end
				end
			end
			BK_EV1: begin
				if (out_free) begin
					out_load = 1'b1;
					if (ev2_vld_q) begin
						mem_re  = 1'b1;
						mem_ra  = ev2_pos_q;
						state_d = BK_EV2;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			BK_EV2: begin
				ld_kind = ev2_kind_q;
				ld_pos  = ev2_pos_q;
				ld_last = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// step table with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= q_cmd.ident;
		end
		if (mem_re) begin
			rd_data_q <= table_mem[mem_ra];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pos_q       <= '0;
			back_q      <= 1'b0;
			active_q    <= 1'b0;
			hold_q      <= '0;
			ev2_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			back_q    <= back_d;
			active_q  <= active_d;
			hold_q    <= hold_d;
			ev2_vld_q <= ev2_vld_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign ld_pos_ext = IW'(ld_pos);

	// pending event payload and output payload
	always_ff @(posedge clk) begin
		ev1_kind_q <= ev1_kind_d;
		ev1_pos_q  <= ev1_pos_d;
		ev1_last_q <= ev1_last_d;
		ev2_kind_q <= ev2_kind_d;
		ev2_pos_q  <= ev2_pos_d;
		if (out_load) begin
			out_kind_q <= ld_kind;
			out_last_q <= ld_last;
			if (ld_kind == EV_FINISH) begin
				out_index_q <= '0;
				out_ident_q <= '0;
			end else begin
				out_index_q <= ld_pos_ext[5:0];
				out_ident_q <= rd_data_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_kind_q;
	assign member_index = out_index_q;
	assign member_ident = out_ident_q;
	assign last_of_run  = out_last_q;

endmodule

// ===== rtl/core/step_chaser_sequencer_core.sv =====
// step_chaser_sequencer_core: top level with configuration registers,
// front end, command queue and back end; uses scs_pkg and all scs_* modules
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  cfg       in/out     psel/penable/pready    paddr, pwdata, prdata
//  in        in         in_valid / in_stall    action, step_slot, step_ident
//  out       out        out_valid / out_stall  event_kind, member_index,
//                                              member_ident, last_of_run
//
// a load completes in the idle state; a transaction with one result also passes through
// BK_EV1, one with two results through BK_EV1 and then BK_EV2; the single read port of the step table
// (one identifier read per result) and the output register set this sequence.
// reset clears run state, queue and output valid; the step table is not cleared.
// a two-entry command queue lets the input side keep going while out is stalled.

module step_chaser_sequencer_core #(
	parameter int MAX_STEPS = scs_pkg::SCS_MAX_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [5:0]  step_slot,
	input  logic [15:0] step_ident,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [5:0]  member_index,
	output logic [15:0] member_ident,
	output logic        last_of_run
);
	import scs_pkg::*;

	cfg_t cfg_q;
	logic cfg_wr;
	logic q_full;
	logic q_push;
	cmd_t push_cmd;
	logic q_pop;
	logic q_not_empty;
	cmd_t head_cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_direction <= RST_START_DIR;
			cfg_q.run_order       <= RST_RUN_ORDER;
			cfg_q.hold_ticks      <= RST_HOLD_TICKS;
			cfg_q.step_count      <= RST_STEP_COUNT;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_START_DIR:  cfg_q.start_direction <= pwdata[0];
				REG_RUN_ORDER:  cfg_q.run_order       <= pwdata[1:0];
				REG_HOLD_TICKS: cfg_q.hold_ticks      <= pwdata[15:0];
				REG_STEP_COUNT: cfg_q.step_count      <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_START_DIR:  prdata = {31'd0, cfg_q.start_direction};
			REG_RUN_ORDER:  prdata = {30'd0, cfg_q.run_order};
			REG_HOLD_TICKS: prdata = {16'd0, cfg_q.hold_ticks};
			REG_STEP_COUNT: prdata = {25'd0, cfg_q.step_count};
			default:        prdata = '0;
		endcase
	end

	scs_front #(
		.MAX_STEPS (MAX_STEPS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.step_slot  (step_slot),
		.step_ident (step_ident),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	scs_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (head_cmd)
	);

	scs_back #(
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.q_cmd        (head_cmd),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.member_index (member_index),
		.member_ident (member_ident),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== sim/step_chaser_sequencer_core_test.sv =====
// step_chaser_sequencer_core_test: self-checking bench for the step chaser sequencer core
// drives loads, starts, ticks, taps and stops, predicts every event and checks it in order
// depends on scs_pkg and rtl/core/step_chaser_sequencer_core.sv
`timescale 1ns / 1ps

module step_chaser_sequencer_core_test;
	import scs_pkg::*;

	localparam int TABLE_DEPTH   = SCS_MAX_STEPS;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_TARGET = 950;
	localparam int MAX_REPORTS   = 10;
	localparam int IDLE_PCT      = 22;

	// action codes the block has no use for
	localparam logic [2:0] ACT_SPARE_A = 3'd5;
	localparam logic [2:0] ACT_SPARE_B = 3'd6;
	localparam logic [2:0] ACT_SPARE_C = 3'd7;
	// run order code outside the defined set, behaves as single shot
	localparam logic [1:0] ORD_SPARE   = 2'd3;

	typedef struct packed {
		ev_kind_t    kind;
		logic [5:0]  pos;
		logic [15:0] ident;
		logic        last;
	} chase_event_t;

	// chase predictor plus the in-order store of events still owed by the block
	class chase_scoreboard;
		logic [15:0]  ident_table [TABLE_DEPTH];
		logic [6:0]   position;
		logic         backward;
		logic         running;
		logic [15:0]  held_ticks;
		logic         cfg_dir;
		logic [1:0]   cfg_order;
		logic [15:0]  cfg_hold;
		logic [6:0]   cfg_count;
		chase_event_t owed_events[$];
		chase_event_t fresh_events[$];
		int           fail_count;

		function new();
			position   = '0;
			backward   = 1'b0;
			running    = 1'b0;
			held_ticks = '0;
			cfg_dir    = RST_START_DIR;
			cfg_order  = RST_RUN_ORDER;
			cfg_hold   = RST_HOLD_TICKS;
			cfg_count  = RST_STEP_COUNT;
			fail_count = 0;
		endfunction

		function void set_register(logic [1:0] reg_index, logic [15:0] value);
			case (reg_index)
				REG_START_DIR:  cfg_dir   = value[0];
				REG_RUN_ORDER:  cfg_order = value[1:0];
				REG_HOLD_TICKS: cfg_hold  = value;
				REG_STEP_COUNT: cfg_count = value[6:0];
				default: ;
			endcase
		endfunction

		function int unsigned live_steps();
			return (cfg_count < TABLE_DEPTH) ? int'(cfg_count) : TABLE_DEPTH;
		endfunction

		function void emit(ev_kind_t kind, logic [6:0] at);
			chase_event_t ev;
			ev.kind  = kind;
			ev.pos   = (kind == EV_FINISH) ? 6'd0 : at[5:0];
			ev.ident = (kind == EV_FINISH) ? 16'd0 : ident_table[at];
			ev.last  = 1'b0;
			fresh_events.push_back(ev);
		endfunction

		// start the step at the current position, or finish when there is none
		function void enter_step(bit ok);
			if (!ok) begin
				running = 1'b0;
				emit(EV_FINISH, 7'd0);
			end else begin
				running    = 1'b1;
				held_ticks = '0;
				emit(EV_START, position);
			end
		endfunction

		// report the stop, then advance by direction and run order
		function void leave_step();
			int unsigned n;
			bit ok;
			n = live_steps();
			emit(EV_STOP, position);
			if (!backward && position + 1 < n) begin
				position = position + 7'd1;
				ok = 1'b1;
			end else if (backward && position > 0 && position - 1 < n) begin
				position = position - 7'd1;
				ok = 1'b1;
			end else if (n == 0 || (cfg_order != ORD_LOOP && cfg_order != ORD_PING)) begin
				ok = 1'b0;
			end else if (cfg_order == ORD_LOOP) begin
				position = backward ? 7'(n - 1) : 7'd0;
				ok = 1'b1;
			end else begin
				// ping-pong turns around without repeating the end step
				if (!backward)
					position = (n >= 2) ? 7'(n - 2) : 7'd0;
				else
					position = (n >= 2) ? 7'd1 : 7'd0;
				backward = !backward;
				ok = 1'b1;
			end
			enter_step(ok);
		endfunction

		// returns 1 when the transaction is not simply ignored
		function bit note_transaction(logic [2:0] act, logic [5:0] slot, logic [15:0] ident);
			bit acted;
			logic [15:0] hold_limit;
			int unsigned n;
			acted = 1'b0;
			hold_limit = (cfg_hold == 16'd0) ? 16'd1 : cfg_hold;
			fresh_events.delete();
			case (act)
				ACT_LOAD: begin
					ident_table[slot] = ident;
					acted = 1'b1;
				end
				ACT_START: begin
					n = live_steps();
					backward = cfg_dir;
					position = (backward && n > 0) ? 7'(n - 1) : 7'd0;
					enter_step(n > 0);
					acted = 1'b1;
				end
				ACT_TICK: begin
					if (running) begin
						held_ticks = held_ticks + 16'd1;
						if (held_ticks >= hold_limit)
							leave_step();
						acted = 1'b1;
					end
				end
				ACT_TAP: begin
					if (running) begin
						leave_step();
						acted = 1'b1;
					end
				end
				ACT_STOP: begin
					if (running) begin
						running = 1'b0;
						emit(EV_FINISH, 7'd0);
						acted = 1'b1;
					end
				end
				default: ;
			endcase
			if (fresh_events.size() > 0)
				fresh_events[fresh_events.size() - 1].last = 1'b1;
			foreach (fresh_events[k])
				owed_events.push_back(fresh_events[k]);
			return acted;
		endfunction

		function void check_event(chase_event_t got);
			chase_event_t want;
			if (owed_events.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected event: kind %0d pos %0d ident %h last %0d",
						got.kind, got.pos, got.ident, got.last);
				return;
			end
			want = owed_events.pop_front();
			if (got.kind !== want.kind || got.pos !== want.pos || got.ident !== want.ident ||
					got.last !== want.last) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("event mismatch: expected kind %0d pos %0d ident %h last %0d, got kind %0d pos %0d ident %h last %0d",
						want.kind, want.pos, want.ident, want.last,
						got.kind, got.pos, got.ident, got.last);
			end
		endfunction

		function int owed_count();
			return owed_events.size();
		endfunction

		function void close_out();
			if (owed_events.size() != 0) begin
				$display("%0d events never arrived", owed_events.size());
				fail_count += owed_events.size();
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [5:0]  step_slot;
	logic [15:0] step_ident;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [5:0]  member_index;
	logic [15:0] member_ident;
	logic        last_of_run;

	chase_scoreboard chase_sb;
	int random_done = 0;
	int cycle_count = 0;
	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;

	step_chaser_sequencer_core #(.MAX_STEPS(TABLE_DEPTH)) i_dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// output side: random stall, event check, run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			chase_sb.check_event({event_kind, member_index, member_ident, last_of_run});
		out_stall <= !quiet_out && ($urandom_range(99) < IDLE_PCT);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one input transaction with random idle cycles ahead of it
	task automatic send_item(input logic [2:0] act, input logic [5:0] slot,
			input logic [15:0] ident, output bit acted);
		while (!quiet_in && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		step_slot  <= slot;
		step_ident <= ident;
		do @(posedge clk); while (in_stall !== 1'b0);
		acted = chase_sb.note_transaction(act, slot, ident);
	endtask

	task automatic send_plain(input logic [2:0] act, input logic [5:0] slot,
			input logic [15:0] ident);
		bit acted;
		send_item(act, slot, ident, acted);
	endtask

	// wait until every owed event is out and queued loads have drained
	task automatic settle();
		in_valid <= 1'b0;
		while (chase_sb.owed_count() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup, access, then idle
	task automatic program_register(input logic [1:0] reg_index, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		chase_sb.set_register(reg_index, value);
		@(posedge clk);
	endtask

	task automatic program_all(input logic dir, input logic [1:0] order,
			input logic [15:0] hold, input logic [6:0] count);
		program_register(REG_START_DIR, {15'd0, dir});
		program_register(REG_RUN_ORDER, {14'd0, order});
		program_register(REG_HOLD_TICKS, hold);
		program_register(REG_STEP_COUNT, {9'd0, count});
	endtask

	// stimulus
	initial begin
		logic [2:0]  act;
		logic [5:0]  slot;
		logic [15:0] ident;
		logic [1:0]  order;
		logic [15:0] hold;
		logic [6:0]  count;
		bit acted;
		int roll;
		int phase_len;
		int taken;

		chase_sb   = new();
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		action     <= ACT_LOAD;
		step_slot  <= '0;
		step_ident <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle block: ticks, taps, stops and spare codes are ignored, empty start finishes
		send_plain(ACT_TICK, 6'd0, 16'd0);
		send_plain(ACT_TAP, 6'd63, 16'hFFFF);
		send_plain(ACT_STOP, 6'd21, 16'h1234);
		send_plain(ACT_SPARE_A, 6'd0, 16'd0);
		send_plain(ACT_SPARE_B, 6'd63, 16'hFFFF);
		send_plain(ACT_SPARE_C, 6'd42, 16'hBEEF);
		send_plain(ACT_START, 6'd0, 16'd0);
		send_plain(ACT_LOAD, 6'd0, 16'h0000);
		send_plain(ACT_LOAD, 6'd1, 16'hFFFF);
		send_plain(ACT_LOAD, 6'd2, 16'hA5A5);
		send_plain(ACT_LOAD, 6'd3, 16'h5A5A);
		send_plain(ACT_LOAD, 6'd63, 16'hFFFF);
		settle();

		// backward ping-pong over four steps with zero hold, restart and stop
		program_all(1'b1, ORD_PING, 16'd0, 7'd4);
		send_plain(ACT_START, 6'd0, 16'd0);
		send_plain(ACT_TICK, 6'd0, 16'd0);
		send_plain(ACT_TAP, 6'd0, 16'd0);
		send_plain(ACT_TAP, 6'd0, 16'd0);
		send_plain(ACT_TAP, 6'd0, 16'd0);
		send_plain(ACT_START, 6'd0, 16'd0);
		send_plain(ACT_STOP, 6'd0, 16'd0);
		send_plain(ACT_STOP, 6'd0, 16'd0);
		send_plain(ACT_START, 6'd0, 16'd0);
		settle();

		// count shrunk under a running step, spare run order ends the pass
		program_all(1'b1, ORD_SPARE, 16'hFFFF, 7'd2);
		send_plain(ACT_TAP, 6'd0, 16'd0);
		settle();

		// ping-pong with a single step repeats it
		program_all(1'b0, ORD_PING, 16'd2, 7'd1);
		send_plain(ACT_START, 6'd0, 16'd0);
		send_plain(ACT_TICK, 6'd0, 16'd0);
		send_plain(ACT_TICK, 6'd0, 16'd0);
		send_plain(ACT_TAP, 6'd0, 16'd0);
		settle();

		// fill the whole table so any step count is safe to run
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			send_item(ACT_LOAD, 6'(s), 16'($urandom_range(65535)), acted);
			random_done++;
		end

		// random phases, each under a fresh configuration
		while (random_done < RANDOM_TARGET) begin
			settle();
			order = ($urandom_range(9) == 0) ? ORD_SPARE : 2'($urandom_range(2));
			case ($urandom_range(9))
				0: hold = 16'd0;
				1: hold = 16'hFFFF;
				2: hold = 16'($urandom_range(65535));
				3, 4: hold = 16'd1;
				default: hold = 16'($urandom_range(5, 2));
			endcase
			case ($urandom_range(9))
				0: count = 7'd0;
				1: count = 7'd1;
				2: count = 7'(TABLE_DEPTH);
				3: count = 7'($urandom_range(TABLE_DEPTH));
				default: count = 7'($urandom_range(8, 2));
			endcase
			program_all(1'($urandom_range(1)), order, hold, count);
			phase_len = $urandom_range(60, 15);
			taken = 0;
			while (taken < phase_len && random_done < RANDOM_TARGET) begin
				roll  = $urandom_range(99);
				slot  = 6'($urandom_range(63));
				ident = 16'($urandom_range(65535));
				if (chase_sb.running) begin
					if (roll < 45)
						act = ACT_TICK;
					else if (roll < 72)
						act = ACT_TAP;
					else if (roll < 78)
						act = ACT_STOP;
					else if (roll < 85)
						act = ACT_START;
					else if (roll < 94)
						act = ACT_LOAD;
					else
						act = 3'($urandom_range(7));
				end else begin
					if (roll < 55)
						act = ACT_START;
					else if (roll < 72)
						act = ACT_LOAD;
					else if (roll < 85)
						act = 3'($urandom_range(ACT_STOP, ACT_TICK));
					else
						act = 3'($urandom_range(7));
				end
				send_item(act, slot, ident, acted);
				if (acted) begin
					taken++;
					random_done++;
				end
				// stretches with no input idling and no output stall
				quiet_in  = (random_done >= 350 && random_done < 500);
				quiet_out = (random_done >= 600 && random_done < 750);
			end
		end

		quiet_in  = 1'b0;
		quiet_out = 1'b0;
		settle();
		chase_sb.close_out();
		if (chase_sb.fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
